@@ sv/att_pkg.sv @@
// ---------------------------------------------------------------------------
// Aircraft track table package
// Widths, field flag positions, sequencer states and the shared compare
// result type used across the track table modules.
// ---------------------------------------------------------------------------
`default_nettype none

package att_pkg;

    localparam int ADDR_W  = 24;
    localparam int FLAG_W  = 7;
    localparam int TIME_W  = 32;
    localparam int CALL_W  = 64;
    localparam int TYPE_W  = 56;
    localparam int LAT_W   = 31;
    localparam int LNG_W   = 32;
    localparam int POS_W   = 64;
    localparam int TRK_W   = 15;
    localparam int SPD_W   = 15;
    localparam int ALT_W   = 18;
    localparam int CLIMB_W = 16;
    localparam int SLOT_W  = 4;

    // Bit positions inside the field valid word.
    localparam int FL_ADDR  = 0;
    localparam int FL_IDENT = 1;
    localparam int FL_POS   = 2;
    localparam int FL_TRK   = 3;
    localparam int FL_SPD   = 4;
    localparam int FL_ALT   = 5;
    localparam int FL_CLIMB = 6;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } t_state;

    // Result of one pass through the shared age and key compare unit.
    typedef struct packed {
        logic [TIME_W-1:0] age;
        logic              older;
        logic              match;
    } t_cmp_res;

endpackage

`default_nettype wire

@@ sv/att_ram.sv @@
// ---------------------------------------------------------------------------
// Generic table RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module att_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ sv/att_age_cmp.sv @@
// ---------------------------------------------------------------------------
// Shared age and key compare unit
// Computes the age of one entry against the current time, compares it with
// the oldest age found so far and checks the entry address against the key.
// ---------------------------------------------------------------------------
`default_nettype none

module att_age_cmp (
    input  wire logic [att_pkg::TIME_W-1:0] i_now,
    input  wire logic [att_pkg::TIME_W-1:0] i_stamp,
    input  wire logic [att_pkg::TIME_W-1:0] i_best_age,
    input  wire logic [att_pkg::ADDR_W-1:0] i_key,
    input  wire logic [att_pkg::ADDR_W-1:0] i_entry_addr,
    output att_pkg::t_cmp_res               o_res
);

    logic [att_pkg::TIME_W-1:0] age;

    // Age wraps modulo 2^32, like the time counter itself.
    assign age         = i_now - i_stamp;
    assign o_res.age   = age;
    assign o_res.older = (age > i_best_age);
    assign o_res.match = (i_entry_addr == i_key);

endmodule

`default_nettype wire

@@ sv/aircraft_track_table_update.sv @@
// ---------------------------------------------------------------------------
// Aircraft track table update
// Fully associative table of aircraft entries keyed by a 24-bit address,
// with replacement of the oldest entry when the table is full.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Contents
//  report    in         i_valid / o_stall   address, ident, position, motion,
//                                           field valid bits, current time
//  result    out        o_valid / i_stall   slot, hit, eviction, merged flags
//  config    in         i_cfg_wr_en         stamp on position only (1 bit)
//
// The scan reads the slots in order, one slot per cycle through the shared
// compare unit, with the entry RAM reads registered before the compare; a
// hit or an empty slot ends the scan early. The chosen slot is then written
// in the write state. No new request is taken until the sequencer is back
// in idle after that write.
// A new request is taken while an earlier result still waits at the output;
// its table write then waits until that result has been taken.
// Reset clears the occupancy bits and the control state at once; there is
// no clearing pass, and the entry RAMs are not reset.
//
// The scan visits slots in order. The first empty slot, or the first
// occupied slot whose address matches, ends the scan. Otherwise the slot
// with the strictly greatest age wins, ties keeping the earlier slot.
// ---------------------------------------------------------------------------
`default_nettype none

module aircraft_track_table_update #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_cfg_wr_en,
    input  wire logic                                i_cfg_wr_data,

    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic        [att_pkg::ADDR_W-1:0]   i_aircraft_address,
    input  wire logic        [att_pkg::CALL_W-1:0]   i_callsign_chars,
    input  wire logic        [att_pkg::TYPE_W-1:0]   i_type_chars,
    input  wire logic signed [att_pkg::LAT_W-1:0]    i_latitude,
    input  wire logic signed [att_pkg::LNG_W-1:0]    i_longitude,
    input  wire logic        [att_pkg::TRK_W-1:0]    i_track_angle,
    input  wire logic        [att_pkg::SPD_W-1:0]    i_ground_speed,
    input  wire logic signed [att_pkg::ALT_W-1:0]    i_altitude_ft,
    input  wire logic signed [att_pkg::CLIMB_W-1:0]  i_climb_rate,
    input  wire logic        [att_pkg::FLAG_W-1:0]   i_field_valid,
    input  wire logic        [att_pkg::TIME_W-1:0]   i_time_now,

    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic             [att_pkg::SLOT_W-1:0]   o_slot_used,
    output logic                                     o_address_hit,
    output logic                                     o_evicted_valid,
    output logic             [att_pkg::ADDR_W-1:0]   o_evicted_address,
    output logic             [att_pkg::FLAG_W-1:0]   o_merged_valid
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    // Control state.
    att_pkg::t_state             r_state, n_state;
    logic [CNT_W-1:0]            r_rd_cnt, n_rd_cnt;
    logic                        r_ev_vld, n_ev_vld;
    logic [IDX_W-1:0]            r_ev_idx;
    logic                        r_ev_occ;
    logic [TABLE_DEPTH-1:0]      r_occ;
    logic                        r_cfg;
    logic                        r_o_valid, n_o_valid;

    // Scan results.
    logic [att_pkg::TIME_W-1:0]  r_best_age, n_best_age;
    logic [IDX_W-1:0]            r_slot, n_slot;
    logic                        r_hit, n_hit;
    logic                        r_empty, n_empty;
    logic [att_pkg::FLAG_W-1:0]  r_old_flags, n_old_flags;
    logic [att_pkg::ADDR_W-1:0]  r_best_addr, n_best_addr;

    // Latched request.
    logic [att_pkg::ADDR_W-1:0]        r_addr;
    logic [att_pkg::CALL_W-1:0]        r_call;
    logic [att_pkg::TYPE_W-1:0]        r_type;
    logic signed [att_pkg::LAT_W-1:0]  r_lat;
    logic [att_pkg::LNG_W-1:0]         r_lng;
    logic [att_pkg::TRK_W-1:0]         r_trk;
    logic [att_pkg::SPD_W-1:0]         r_spd;
    logic [att_pkg::ALT_W-1:0]         r_alt;
    logic [att_pkg::CLIMB_W-1:0]       r_climb;
    logic [att_pkg::FLAG_W-1:0]        r_fl;
    logic [att_pkg::TIME_W-1:0]        r_now;

    // Result registers.
    logic [att_pkg::SLOT_W-1:0]  r_o_slot;
    logic                        r_o_hit;
    logic                        r_o_ev;
    logic [att_pkg::ADDR_W-1:0]  r_o_ev_addr;
    logic [att_pkg::FLAG_W-1:0]  r_o_merged;

    logic                        accept;
    logic                        issue;
    logic                        last_slot;
    logic                        wr_go;
    logic                        evict;
    logic [IDX_W-1:0]            rd_idx;
    logic [att_pkg::FLAG_W-1:0]  merged;
    logic [att_pkg::ADDR_W-1:0]  ram_addr_q;
    logic [att_pkg::TIME_W-1:0]  ram_stamp_q;
    logic [att_pkg::FLAG_W-1:0]  ram_flags_q;
    logic [att_pkg::POS_W-1:0]   pos_word;
    att_pkg::t_cmp_res           cmp;

    assign o_stall   = (r_state != att_pkg::ST_IDLE);
    assign accept    = i_valid && !o_stall;
    assign rd_idx    = r_rd_cnt[IDX_W-1:0];
    assign issue     = (r_rd_cnt < CNT_W'(TABLE_DEPTH));
    assign last_slot = (r_ev_idx == IDX_W'(TABLE_DEPTH - 1));
    assign wr_go     = (r_state == att_pkg::ST_WRITE) && (!r_o_valid || !i_stall);
    assign evict     = !r_hit && !r_empty;
    assign merged    = r_hit ? (r_old_flags | r_fl) : r_fl;
    // Latitude is stored sign-extended to 32 bits.
    assign pos_word  = {r_lng, r_lat[att_pkg::LAT_W-1], r_lat};

    att_age_cmp u_cmp (
        .i_now        (r_now),
        .i_stamp      (ram_stamp_q),
        .i_best_age   (r_best_age),
        .i_key        (r_addr),
        .i_entry_addr (ram_addr_q),
        .o_res        (cmp)
    );

    // Sequencer: idle, scan one slot per cycle, then write the chosen slot.
    always_comb begin
        n_state     = r_state;
        n_rd_cnt    = r_rd_cnt;
        n_ev_vld    = r_ev_vld;
        n_best_age  = r_best_age;
        n_slot      = r_slot;
        n_hit       = r_hit;
        n_empty     = r_empty;
        n_old_flags = r_old_flags;
        n_best_addr = r_best_addr;
        n_o_valid   = r_o_valid && i_stall;

        unique case (r_state)
            att_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state    = att_pkg::ST_SCAN;
                    n_rd_cnt   = '0;
                    n_ev_vld   = 1'b0;
                    n_best_age = '0;
                    n_slot     = '0;
                    n_hit      = 1'b0;
                    n_empty    = 1'b0;
                end
            end
            att_pkg::ST_SCAN: begin
                if (issue) begin
                    n_rd_cnt = r_rd_cnt + CNT_W'(1);
                end
                n_ev_vld = issue;
                if (r_ev_vld) begin
                    if (!r_ev_occ) begin
                        // An empty slot is always taken as new, whatever
                        // address it still holds.
                        n_slot   = r_ev_idx;
                        n_empty  = 1'b1;
                        n_ev_vld = 1'b0;
                        n_state  = att_pkg::ST_WRITE;
                    end else if (cmp.match) begin
                        n_slot      = r_ev_idx;
                        n_hit       = 1'b1;
                        n_old_flags = ram_flags_q;
                        n_ev_vld    = 1'b0;
                        n_state     = att_pkg::ST_WRITE;
                    end else begin
                        // Slot 0 is the starting candidate even at age zero.
                        if (cmp.older || (r_ev_idx == '0)) begin
                            n_best_age  = cmp.age;
                            n_slot      = r_ev_idx;
                            n_best_addr = ram_addr_q;
                        end
                        if (last_slot) begin
                            n_ev_vld = 1'b0;
                            n_state  = att_pkg::ST_WRITE;
                        end
                    end
                end
            end
            att_pkg::ST_WRITE: begin
                if (wr_go) begin
                    n_o_valid = 1'b1;
                    n_state   = att_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = att_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= att_pkg::ST_IDLE;
            r_rd_cnt  <= '0;
            r_ev_vld  <= 1'b0;
            r_occ     <= '0;
            r_cfg     <= 1'b0;
            r_o_valid <= 1'b0;
            r_hit     <= 1'b0;
            r_empty   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_cnt  <= n_rd_cnt;
            r_ev_vld  <= n_ev_vld;
            r_o_valid <= n_o_valid;
            r_hit     <= n_hit;
            r_empty   <= n_empty;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (wr_go) begin
                r_occ[r_slot] <= merged[att_pkg::FL_ADDR];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_age  <= n_best_age;
        r_slot      <= n_slot;
        r_old_flags <= n_old_flags;
        r_best_addr <= n_best_addr;
        r_ev_idx    <= rd_idx;
        r_ev_occ    <= r_occ[rd_idx];
        if (accept) begin
            r_addr  <= i_aircraft_address;
            r_call  <= i_callsign_chars;
            r_type  <= i_type_chars;
            r_lat   <= i_latitude;
            r_lng   <= i_longitude;
            r_trk   <= i_track_angle;
            r_spd   <= i_ground_speed;
            r_alt   <= i_altitude_ft;
            r_climb <= i_climb_rate;
            r_fl    <= i_field_valid;
            r_now   <= i_time_now;
        end
        if (wr_go) begin
            r_o_slot    <= att_pkg::SLOT_W'(r_slot);
            r_o_hit     <= r_hit;
            r_o_ev      <= evict;
            r_o_ev_addr <= evict ? r_best_addr : '0;
            r_o_merged  <= merged;
        end
    end

    // Entry stores. Address, stamp and flags are read during the scan; the
    // report fields are only written here.
    att_ram #(.WIDTH(att_pkg::ADDR_W), .DEPTH(TABLE_DEPTH)) u_ram_addr (
        .i_clk     (i_clk),
        .i_wr_en   (wr_go),
        .i_wr_addr (r_slot),
        .i_wr_data (r_addr),
        .i_rd_addr (rd_idx),
        .o_rd_data (ram_addr_q)
    );

    att_ram #(.WIDTH(att_pkg::TIME_W), .DEPTH(TABLE_DEPTH)) u_ram_stamp (
        .i_clk     (i_clk),
        .i_wr_en   (wr_go && (!r_cfg || r_fl[att_pkg::FL_POS])),
        .i_wr_addr (r_slot),
        .i_wr_data (r_now),
        .i_rd_addr (rd_idx),
        .o_rd_data (ram_stamp_q)
    );

    att_ram #(.WIDTH(att_pkg::FLAG_W), .DEPTH(TABLE_DEPTH)) u_ram_flags (
        .i_clk     (i_clk),
        .i_wr_en   (wr_go),
        .i_wr_addr (r_slot),
        .i_wr_data (merged),
        .i_rd_addr (rd_idx),
        .o_rd_data (ram_flags_q)
    );

    att_ram #(.WIDTH(att_pkg::CALL_W + att_pkg::TYPE_W), .DEPTH(TABLE_DEPTH)) u_ram_ident (
        .i_clk     (i_clk),
        .i_wr_en   (wr_go && r_fl[att_pkg::FL_IDENT]),
        .i_wr_addr (r_slot),
        .i_wr_data ({r_call, r_type}),
        .i_rd_addr (rd_idx),
        .o_rd_data ()
    );

    att_ram #(.WIDTH(att_pkg::POS_W), .DEPTH(TABLE_DEPTH)) u_ram_pos (
        .i_clk     (i_clk),
        .i_wr_en   (wr_go && r_fl[att_pkg::FL_POS]),
        .i_wr_addr (r_slot),
        .i_wr_data (pos_word),
        .i_rd_addr (rd_idx),
        .o_rd_data ()
    );

    att_ram #(.WIDTH(att_pkg::TRK_W), .DEPTH(TABLE_DEPTH)) u_ram_trk (
        .i_clk     (i_clk),
        .i_wr_en   (wr_go && r_fl[att_pkg::FL_TRK]),
        .i_wr_addr (r_slot),
        .i_wr_data (r_trk),
        .i_rd_addr (rd_idx),
        .o_rd_data ()
    );

    att_ram #(.WIDTH(att_pkg::SPD_W), .DEPTH(TABLE_DEPTH)) u_ram_spd (
        .i_clk     (i_clk),
        .i_wr_en   (wr_go && r_fl[att_pkg::FL_SPD]),
        .i_wr_addr (r_slot),
        .i_wr_data (r_spd),
        .i_rd_addr (rd_idx),
        .o_rd_data ()
    );

    att_ram #(.WIDTH(att_pkg::ALT_W), .DEPTH(TABLE_DEPTH)) u_ram_alt (
        .i_clk     (i_clk),
        .i_wr_en   (wr_go && r_fl[att_pkg::FL_ALT]),
        .i_wr_addr (r_slot),
        .i_wr_data (r_alt),
        .i_rd_addr (rd_idx),
        .o_rd_data ()
    );

    att_ram #(.WIDTH(att_pkg::CLIMB_W), .DEPTH(TABLE_DEPTH)) u_ram_climb (
        .i_clk     (i_clk),
        .i_wr_en   (wr_go && r_fl[att_pkg::FL_CLIMB]),
        .i_wr_addr (r_slot),
        .i_wr_data (r_climb),
        .i_rd_addr (rd_idx),
        .o_rd_data ()
    );

    assign o_valid           = r_o_valid;
    assign o_slot_used       = r_o_slot;
    assign o_address_hit     = r_o_hit;
    assign o_evicted_valid   = r_o_ev;
    assign o_evicted_address = r_o_ev_addr;
    assign o_merged_valid    = r_o_merged;

endmodule

`default_nettype wire

@@ sv/att_chk.sv @@
// ---------------------------------------------------------------------------
// Aircraft track table port checker
// Watches the top-level ports for busy, result and handshake consistency.
// ---------------------------------------------------------------------------
`default_nettype none

module att_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_stall,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic [att_pkg::SLOT_W-1:0]  o_slot_used,
    input wire logic                        o_address_hit,
    input wire logic                        o_evicted_valid,
    input wire logic [att_pkg::ADDR_W-1:0]  o_evicted_address,
    input wire logic [att_pkg::FLAG_W-1:0]  o_merged_valid
);

    // A request keeps the block busy in the following cycle.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a request");

    // A stalled result holds until it is taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_slot_used)
            && $stable(o_merged_valid) && $stable(o_evicted_address)))
        else $error("stalled result changed or dropped");

    // The evicted address reads zero unless an eviction is reported.
    a_evict_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted_valid) |-> (o_evicted_address == '0))
        else $error("evicted address nonzero without eviction");

    // A hit never evicts, and a hit entry stays occupied.
    a_hit_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_address_hit) |->
            (!o_evicted_valid && o_merged_valid[att_pkg::FL_ADDR]))
        else $error("hit result inconsistent");

endmodule

bind aircraft_track_table_update att_chk u_att_chk (.*);

`default_nettype wire
